// ===== rtl/bsbl_pkg.sv =====
// ----------------------------------------------------------------------------
// bsbl_pkg
// Shared types and constants for the button, screen and backlight controller.
// ----------------------------------------------------------------------------
package bsbl_pkg;

  localparam int unsigned TICK_W    = 32;
  localparam int unsigned SCREEN_W  = 2;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DAT_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REFRESH_PERIOD = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_PRESENT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_PRESENT = 3'd5;

  // reset values
  localparam logic [TICK_W-1:0] RST_LONG_PRESS     = 32'd3000;
  localparam logic [TICK_W-1:0] RST_DEBOUNCE       = 32'd200;
  localparam logic [TICK_W-1:0] RST_IDLE_TIMEOUT   = 32'd60000;
  localparam logic [TICK_W-1:0] RST_REFRESH_PERIOD = 32'd2000;

  // screens
  localparam logic [SCREEN_W-1:0] SCREEN_MINING  = 2'd0;
  localparam logic [SCREEN_W-1:0] SCREEN_STATS   = 2'd1;
  localparam logic [SCREEN_W-1:0] SCREEN_NETWORK = 2'd2;

  typedef struct packed {
    logic [TICK_W-1:0] long_press;
    logic [TICK_W-1:0] debounce;
    logic [TICK_W-1:0] idle_timeout;
    logic [TICK_W-1:0] refresh_period;
    logic              first_present;
    logic              second_present;
  } bsbl_cfg_t;

  typedef struct packed {
    logic                lit;
    logic [SCREEN_W-1:0] screen;
    logic                first_was_down;
    logic                second_was_down;
    logic [TICK_W-1:0]   first_press_time;
    logic [TICK_W-1:0]   last_activity_time;
    logic [TICK_W-1:0]   last_refresh_time;
    logic                release_wait;
  } bsbl_state_t;

  localparam bsbl_state_t STATE_RST = '{
    lit:                1'b1,
    screen:             SCREEN_MINING,
    first_was_down:     1'b0,
    second_was_down:    1'b0,
    first_press_time:   '0,
    last_activity_time: '0,
    last_refresh_time:  '0,
    release_wait:       1'b0
  };

  typedef struct packed {
    logic                backlight_lit;
    logic [SCREEN_W-1:0] screen_index;
    logic                refresh_now;
    logic                awaiting_release;
  } bsbl_result_t;

  function automatic logic [SCREEN_W-1:0] next_screen(input logic [SCREEN_W-1:0] s);
    logic [SCREEN_W-1:0] r;
    case (s)
      SCREEN_MINING: r = SCREEN_STATS;
      SCREEN_STATS:  r = SCREEN_NETWORK;
      default:       r = SCREEN_MINING;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/bsbl_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// bsbl_cfg_regs
// Configuration register file, write-only, indexed writes.
// ----------------------------------------------------------------------------
module bsbl_cfg_regs
  import bsbl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  output bsbl_cfg_t            cfg_o
);

  bsbl_cfg_t cfg_r;
  bsbl_cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_LONG_PRESS:     cfg_nxt.long_press     = cfg_wdata;
        REG_DEBOUNCE:       cfg_nxt.debounce       = cfg_wdata;
        REG_IDLE_TIMEOUT:   cfg_nxt.idle_timeout   = cfg_wdata;
        REG_REFRESH_PERIOD: cfg_nxt.refresh_period = cfg_wdata;
        REG_FIRST_PRESENT:  cfg_nxt.first_present  = cfg_wdata[0];
        REG_SECOND_PRESENT: cfg_nxt.second_present = cfg_wdata[0];
        default: ;  // unmapped index, ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.long_press     <= RST_LONG_PRESS;
      cfg_r.debounce       <= RST_DEBOUNCE;
      cfg_r.idle_timeout   <= RST_IDLE_TIMEOUT;
      cfg_r.refresh_period <= RST_REFRESH_PERIOD;
      cfg_r.first_present  <= 1'b1;
      cfg_r.second_present <= 1'b1;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ===== rtl/bsbl_step.sv =====
// ----------------------------------------------------------------------------
// bsbl_step
// Next-state and result logic for one button poll.
// ----------------------------------------------------------------------------
module bsbl_step
  import bsbl_pkg::*;
(
  input  bsbl_cfg_t         cfg_i,
  input  bsbl_state_t       st_i,
  input  logic              first_down_i,
  input  logic              second_down_i,
  input  logic [TICK_W-1:0] now_i,
  output bsbl_state_t       st_o,
  output bsbl_result_t      res_o
);

  logic              b1;
  logic              b2;
  logic              hold_wait;
  logic              fwd;
  logic              fresh;
  logic [TICK_W-1:0] hold;
  logic [TICK_W-1:0] idle_el;
  logic [TICK_W-1:0] refr_el;
  logic              toggle;
  logic              short_press;
  logic              lit_wake;
  logic              refresh;

  always_comb begin
    b1        = first_down_i  & cfg_i.first_present;
    b2        = second_down_i & cfg_i.second_present;
    hold_wait = st_i.release_wait & (b1 | b2);
    // leaving release wait clears the was-down flags
    fwd       = st_i.release_wait ? 1'b0 : st_i.first_was_down;
    fresh     = b1 & ~fwd;
    hold      = fresh ? '0 : now_i - st_i.first_press_time;
    toggle    = b1 & b2 & (hold >= cfg_i.long_press);
    short_press = ~b1 & fwd & ~b2 & (hold < cfg_i.long_press) & (hold >= cfg_i.debounce);
    idle_el   = short_press ? '0 : now_i - st_i.last_activity_time;
    refr_el   = now_i - st_i.last_refresh_time;
    lit_wake  = short_press | st_i.lit;
    refresh   = short_press | (refr_el >= cfg_i.refresh_period);

    st_o    = st_i;
    refresh = refresh & ~hold_wait & ~toggle;
    if (hold_wait) begin
      st_o = st_i;
    end else if (toggle) begin
      st_o.first_press_time   = now_i;  // toggle implies fresh or earlier press
      if (!fresh) st_o.first_press_time = st_i.first_press_time;
      st_o.lit                = ~st_i.lit;
      st_o.last_activity_time = now_i;
      st_o.release_wait       = 1'b1;
      st_o.first_was_down     = 1'b0;
      st_o.second_was_down    = 1'b0;
    end else begin
      st_o.release_wait     = 1'b0;
      st_o.first_press_time = fresh ? now_i : st_i.first_press_time;
      st_o.first_was_down   = b1;
      st_o.second_was_down  = b2;
      if (short_press) begin
        st_o.last_activity_time = now_i;
        if (st_i.lit) st_o.screen = next_screen(st_i.screen);
      end
      st_o.lit = lit_wake & ~(idle_el >= cfg_i.idle_timeout);
      if (refresh) st_o.last_refresh_time = now_i;
    end

    res_o.backlight_lit    = st_o.lit;
    res_o.screen_index     = st_o.screen;
    res_o.refresh_now      = refresh;
    res_o.awaiting_release = st_o.release_wait;
  end

endmodule

// ===== rtl/button_screen_backlight_controller_unit.sv =====
// ----------------------------------------------------------------------------
// button_screen_backlight_controller_unit
// Button poll decoder driving backlight, screen selection and refresh pulses.
// ----------------------------------------------------------------------------
// One poll is accepted per clock cycle unless the input stalls. A poll is
// captured in an input register, evaluated against the controller state in
// one pass of compare logic, and its result then moves into an output
// register once that register is free. The output register decouples the
// channels: a new poll is taken while a finished result waits, and the input
// stalls only when both the input and output registers are full and the
// output is stalled. All tick differences wrap modulo 2^32. Configuration
// may be written only while no poll is in flight.
module button_screen_backlight_controller_unit
  import bsbl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_first_down,
  input  logic                 in_second_down,
  input  logic [TICK_W-1:0]    in_tick_now,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_backlight_lit,
  output logic [SCREEN_W-1:0]  out_screen_index,
  output logic                 out_refresh_now,
  output logic                 out_awaiting_release
);

  bsbl_cfg_t    cfg;
  bsbl_state_t  st_r;
  bsbl_state_t  st_nxt;
  bsbl_result_t res_nxt;
  bsbl_result_t res_r;

  logic              in_valid_r;
  logic              first_down_r;
  logic              second_down_r;
  logic [TICK_W-1:0] tick_now_r;
  logic              out_valid_r;
  logic              adv;
  logic              in_acc;

  bsbl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  bsbl_step u_step (
    .cfg_i         (cfg),
    .st_i          (st_r),
    .first_down_i  (first_down_r),
    .second_down_i (second_down_r),
    .now_i         (tick_now_r),
    .st_o          (st_nxt),
    .res_o         (res_nxt)
  );

  // input register moves to the output register when the latter is free
  assign adv      = in_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = in_valid_r & ~adv;
  assign in_acc   = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= STATE_RST;
    end else begin
      if (in_acc) in_valid_r <= 1'b1;
      else if (adv) in_valid_r <= 1'b0;
      if (adv) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      first_down_r  <= in_first_down;
      second_down_r <= in_second_down;
      tick_now_r    <= in_tick_now;
    end
    if (adv) res_r <= res_nxt;
  end

  assign out_valid            = out_valid_r;
  assign out_backlight_lit    = res_r.backlight_lit;
  assign out_screen_index     = res_r.screen_index;
  assign out_refresh_now      = res_r.refresh_now;
  assign out_awaiting_release = res_r.awaiting_release;

  a_no_refresh_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_r.awaiting_release |-> !res_r.refresh_now)
    else $error("refresh pulse while awaiting release");

  a_screen_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.screen != 2'd3)
    else $error("screen index out of range");

  a_item_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !adv |=> in_valid_r && $stable(tick_now_r))
    else $error("pending poll lost");

  a_state_only_on_adv: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(st_r))
    else $error("state changed without a poll");

endmodule

// ===== bench/button_screen_backlight_controller_unit_tb.sv =====
// ----------------------------------------------------------------------------
// button_screen_backlight_controller_unit_tb
// Self-checking bench for the button, screen and backlight controller.
// Polls are driven on a valid/stall channel with random gaps and the result
// channel is stalled at random. A behavioral copy of the controller predicts
// one status item per accepted poll, and each status item that leaves the
// block is compared field by field with the oldest prediction. Directed polls
// cover the threshold edges, toggle and release, wake and timeout, tick wrap,
// zero and all-ones thresholds and unwired buttons. Random phases then run
// press, hold, idle and noise sequences under several register settings.
// ----------------------------------------------------------------------------
module button_screen_backlight_controller_unit_tb;
  import bsbl_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned SHOW_LIMIT  = 10;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = REG_SECOND_PRESENT + 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = REG_SECOND_PRESENT + 3'd2;

  logic                 clk            = 1'b0;
  logic                 rst_n          = 1'b0;
  logic                 cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index      = '0;
  logic [CFG_DAT_W-1:0] cfg_wdata      = '0;
  logic                 in_valid       = 1'b0;
  logic                 in_stall;
  logic                 in_first_down  = 1'b0;
  logic                 in_second_down = 1'b0;
  logic [TICK_W-1:0]    in_tick_now    = '0;
  logic                 out_valid;
  logic                 out_stall      = 1'b0;
  logic                 out_backlight_lit;
  logic [SCREEN_W-1:0]  out_screen_index;
  logic                 out_refresh_now;
  logic                 out_awaiting_release;

  button_screen_backlight_controller_unit u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_first_down       (in_first_down),
    .in_second_down      (in_second_down),
    .in_tick_now         (in_tick_now),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_backlight_lit   (out_backlight_lit),
    .out_screen_index    (out_screen_index),
    .out_refresh_now     (out_refresh_now),
    .out_awaiting_release(out_awaiting_release)
  );

  always #10 clk = ~clk;

  // controller copy used for prediction
  bsbl_cfg_t cfg_m = '{RST_LONG_PRESS, RST_DEBOUNCE, RST_IDLE_TIMEOUT,
                       RST_REFRESH_PERIOD, 1'b1, 1'b1};
  bsbl_state_t ctl = STATE_RST;
  bsbl_result_t expected_status[$];

  logic              gaps_on    = 1'b0;
  logic              stall_on   = 1'b0;
  int unsigned       stall_left = 0;
  logic [TICK_W-1:0] tick_cur   = '0;

  int unsigned cycle_cnt    = 0;
  int unsigned err_cnt      = 0;
  int unsigned polls_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned settings_cnt = 1;
  int unsigned n_toggles    = 0;
  int unsigned n_short      = 0;
  int unsigned n_dark       = 0;
  int unsigned n_refresh    = 0;

  task automatic note_error(input string msg);
    err_cnt++;
    if (err_cnt <= SHOW_LIMIT)
      $display("ERROR: %s", msg);
  endtask

  function automatic bsbl_result_t predict_poll(input logic f_in, input logic s_in,
                                                input logic [TICK_W-1:0] now);
    logic              b1, b2, redraw, refresh, ended;
    logic [TICK_W-1:0] hold, idle, since;
    bsbl_result_t      r;
    b1      = f_in & cfg_m.first_present;
    b2      = s_in & cfg_m.second_present;
    redraw  = 1'b0;
    refresh = 1'b0;
    ended   = 1'b0;
    if (ctl.release_wait) begin
      if (b1 || b2) begin
        ended = 1'b1;
      end else begin
        ctl.release_wait    = 1'b0;
        ctl.first_was_down  = 1'b0;
        ctl.second_was_down = 1'b0;
      end
    end
    if (!ended) begin
      if (b1 && !ctl.first_was_down)
        ctl.first_press_time = now;
      hold = now - ctl.first_press_time;
      if (b1 && b2 && hold >= cfg_m.long_press) begin
        ctl.lit                = ~ctl.lit;
        ctl.last_activity_time = now;
        ctl.release_wait       = 1'b1;
        ctl.first_was_down     = 1'b0;
        ctl.second_was_down    = 1'b0;
        ended                  = 1'b1;
        n_toggles++;
      end
    end
    if (!ended) begin
      if (!b1 && ctl.first_was_down && !b2 &&
          hold < cfg_m.long_press && hold >= cfg_m.debounce) begin
        ctl.last_activity_time = now;
        if (!ctl.lit) begin
          ctl.lit = 1'b1;
        end else begin
          case (ctl.screen)
            SCREEN_MINING: ctl.screen = SCREEN_STATS;
            SCREEN_STATS:  ctl.screen = SCREEN_NETWORK;
            default:       ctl.screen = SCREEN_MINING;
          endcase
        end
        redraw = 1'b1;
        n_short++;
      end
      ctl.first_was_down  = b1;
      ctl.second_was_down = b2;
      idle = now - ctl.last_activity_time;
      if (ctl.lit && idle >= cfg_m.idle_timeout) begin
        ctl.lit = 1'b0;
        n_dark++;
      end
      since = now - ctl.last_refresh_time;
      if (redraw || since >= cfg_m.refresh_period) begin
        ctl.last_refresh_time = now;
        refresh = 1'b1;
        n_refresh++;
      end
    end
    r.backlight_lit    = ctl.lit;
    r.screen_index     = ctl.screen;
    r.refresh_now      = refresh;
    r.awaiting_release = ctl.release_wait;
    return r;
  endfunction

  // mostly short, now and then long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  function automatic logic [TICK_W-1:0] step_for(input logic [TICK_W-1:0] th);
    return (th > 32'd2000) ? 32'd1000 : (th >> 1) + 32'd1;
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("button_screen_backlight_controller_unit test failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!stall_on) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end else begin
      out_stall  <= ~out_stall;
      stall_left <= pick_gap();
    end
  end

  // result check first, then the prediction for a poll taken at this edge
  always @(posedge clk) begin : check_results
    bsbl_result_t want, got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_backlight_lit, out_screen_index, out_refresh_now, out_awaiting_release};
        results_seen++;
        if (expected_status.size() == 0) begin
          note_error($sformatf("unexpected item lit=%0b screen=%0d refresh=%0b wait=%0b",
                               got.backlight_lit, got.screen_index, got.refresh_now,
                               got.awaiting_release));
        end else begin
          want = expected_status.pop_front();
          if (got.backlight_lit !== want.backlight_lit ||
              got.screen_index !== want.screen_index ||
              got.refresh_now !== want.refresh_now ||
              got.awaiting_release !== want.awaiting_release)
            note_error($sformatf({"item %0d: expected lit=%0b screen=%0d refresh=%0b wait=%0b,",
                                  " got lit=%0b screen=%0d refresh=%0b wait=%0b"},
                                 results_seen, want.backlight_lit, want.screen_index,
                                 want.refresh_now, want.awaiting_release,
                                 got.backlight_lit, got.screen_index, got.refresh_now,
                                 got.awaiting_release));
        end
      end
      if (in_valid && !in_stall)
        expected_status.push_back(predict_poll(in_first_down, in_second_down, in_tick_now));
    end
  end

  task automatic send_item(input logic f, input logic s, input logic [TICK_W-1:0] t);
    int unsigned gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_first_down  <= f;
    in_second_down <= s;
    in_tick_now    <= t;
    do @(posedge clk); while (in_stall);
    polls_sent++;
  endtask

  task automatic poll(input logic f, input logic s, input logic [TICK_W-1:0] dt);
    tick_cur = tick_cur + dt;
    send_item(f, s, tick_cur);
  endtask

  // no poll in flight once every status item is back and the pipe has emptied
  task automatic settle();
    in_valid <= 1'b0;
    // let the prediction for the last accepted poll be queued first
    @(posedge clk);
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_LONG_PRESS:     cfg_m.long_press     = data;
      REG_DEBOUNCE:       cfg_m.debounce       = data;
      REG_IDLE_TIMEOUT:   cfg_m.idle_timeout   = data;
      REG_REFRESH_PERIOD: cfg_m.refresh_period = data;
      REG_FIRST_PRESENT:  cfg_m.first_present  = data[0];
      REG_SECOND_PRESENT: cfg_m.second_present = data[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic write_all(input logic [TICK_W-1:0] lp, input logic [TICK_W-1:0] db,
                           input logic [TICK_W-1:0] it, input logic [TICK_W-1:0] rp,
                           input logic fp, input logic sp);
    write_reg(REG_LONG_PRESS, lp);
    write_reg(REG_DEBOUNCE, db);
    write_reg(REG_IDLE_TIMEOUT, it);
    write_reg(REG_REFRESH_PERIOD, rp);
    write_reg(REG_FIRST_PRESENT, {31'd0, fp});
    write_reg(REG_SECOND_PRESENT, {31'd0, sp});
    settings_cnt++;
  endtask

  task automatic test_reset_defaults();
    gaps_on  = 1'b1;
    stall_on = 1'b1;
    send_item(1'b0, 1'b0, 32'd0);
    send_item(1'b0, 1'b0, 32'd2000);      // refresh period reached
    send_item(1'b1, 1'b0, 32'd2100);
    send_item(1'b0, 1'b0, 32'd2299);      // one tick under debounce
    send_item(1'b1, 1'b0, 32'd2300);
    send_item(1'b0, 1'b0, 32'd2500);      // exactly debounce
    send_item(1'b1, 1'b0, 32'd2600);
    send_item(1'b0, 1'b0, 32'd5599);      // one tick under long press
    send_item(1'b1, 1'b1, 32'd6000);
    send_item(1'b1, 1'b1, 32'd9000);      // long press, backlight off
    send_item(1'b0, 1'b1, 32'd9100);      // still held, nothing else happens
    send_item(1'b0, 1'b0, 32'd9200);
    send_item(1'b1, 1'b0, 32'd9300);
    send_item(1'b0, 1'b0, 32'd9600);      // short press wakes
    send_item(1'b0, 1'b0, 32'd69600);     // idle timeout
    send_item(1'b1, 1'b0, 32'hFFFF_FF00);
    send_item(1'b0, 1'b0, 32'h0000_0100); // hold spans tick wrap
  endtask

  task automatic test_threshold_extremes();
    logic [TICK_W-1:0] t;
    settle();
    write_all('0, '0, '0, '0, 1'b1, 1'b1);
    send_item(1'b0, 1'b0, $urandom());
    send_item(1'b1, 1'b0, 32'd10);
    send_item(1'b1, 1'b1, 32'd10);        // zero hold already counts as long
    send_item(1'b0, 1'b0, 32'd11);
    send_item(1'b1, 1'b0, 32'd12);
    send_item(1'b0, 1'b0, 32'd500);       // no hold is under a zero long press
    settle();
    write_all('1, '1, '1, '1, 1'b1, 1'b1);
    t = $urandom();
    send_item(1'b1, 1'b1, t);
    send_item(1'b1, 1'b1, t - 32'd1);     // largest wrapped difference
    send_item(1'b0, 1'b0, t);
    send_item(1'b1, 1'b0, t);
    send_item(1'b0, 1'b0, t - 32'd2);
  endtask

  task automatic test_absent_buttons();
    settle();
    write_reg(REG_FIRST_PRESENT, 32'hFFFF_FFFE);  // only bit 0 counts
    write_reg(REG_SECOND_PRESENT, 32'h0000_0000);
    write_reg(REG_SPARE_LO, $urandom());
    write_reg(REG_SPARE_HI, $urandom());
    write_reg(REG_IDLE_TIMEOUT, 32'd100);
    settings_cnt++;
    send_item(1'b1, 1'b1, 32'd1000);
    send_item(1'b1, 1'b0, 32'd5000);
    send_item(1'b0, 1'b0, 32'd5300);
  endtask

  task automatic run_sequence();
    int unsigned       kind, n;
    logic [TICK_W-1:0] pstep, istep, held, dt;
    pstep = step_for(cfg_m.long_press);
    istep = step_for(cfg_m.idle_timeout);
    kind  = $urandom_range(0, 99);
    if (kind < 35) begin
      // short press candidate on button one
      repeat ($urandom_range(1, 4)) poll(1'b1, 1'b0, $urandom_range(0, pstep));
      poll(1'b0, 1'b0, $urandom_range(0, pstep));
    end else if (kind < 55) begin
      // hold both until long press or for at most 12 polls, then let go in any order
      poll(1'b1, 1'($urandom_range(0, 1)), $urandom_range(0, pstep));
      held = '0;
      n    = 0;
      while (held < cfg_m.long_press && n < 12) begin
        dt   = $urandom_range(1, pstep);
        held = held + dt;
        poll(1'b1, 1'b1, dt);
        n++;
      end
      repeat ($urandom_range(0, 3))
        poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom_range(0, pstep));
      poll(1'b0, 1'b0, $urandom_range(0, pstep));
    end else if (kind < 70) begin
      repeat ($urandom_range(2, 8)) poll(1'b0, 1'b0, $urandom_range(0, 2 * istep));
    end else if (kind < 80) begin
      // button two held while button one comes and goes
      repeat ($urandom_range(1, 4))
        poll(1'($urandom_range(0, 1)), 1'b1, $urandom_range(0, pstep));
      poll(1'b0, 1'b0, $urandom_range(0, pstep));
    end else begin
      repeat ($urandom_range(1, 4)) begin
        if ($urandom_range(0, 4) == 0)
          tick_cur = $urandom();
        poll(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
             $urandom_range(0, 2 * pstep));
      end
    end
  endtask

  task automatic test_random_polls();
    logic [TICK_W-1:0] lp, db, it, rp;
    logic              fp, sp;
    int unsigned       target;
    for (int p = 0; p < 8; p++) begin
      lp = $urandom_range(40, 400);
      db = $urandom_range(0, 40);
      it = $urandom_range(300, 4000);
      rp = $urandom_range(20, 400);
      fp = 1'b1;
      sp = 1'b1;
      case (p)
        2: begin db = '0; rp = '0; end
        3: begin lp = '1; db = '0; it = '1; end
        4: it = '0;
        5: fp = 1'b0;
        6: sp = 1'b0;
        7: begin lp = 32'd1; db = $urandom_range(0, 2); rp = '1; end
        default: ;
      endcase
      settle();
      gaps_on  = (p != 0 && p != 6);
      stall_on = (p != 0 && p != 5);
      write_all(lp, db, it, rp, fp, sp);
      tick_cur = (p == 3) ? 32'hFFFF_FC00 : $urandom();
      target   = polls_sent + 190;
      while (polls_sent < target) run_sequence();
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_threshold_extremes();
    test_absent_buttons();
    test_random_polls();
    settle();
    repeat (10) @(posedge clk);
    if (expected_status.size() != 0)
      note_error($sformatf("%0d status items never arrived", expected_status.size()));
    $display("Ran %0d polls under %0d register settings, %0d status items checked, %0d errors.",
             polls_sent, settings_cnt, results_seen, err_cnt);
    $display("Seen: %0d backlight toggles, %0d short presses, %0d idle timeouts, %0d refreshes.",
             n_toggles, n_short, n_dark, n_refresh);
    if (err_cnt == 0) begin
      $display("button_screen_backlight_controller_unit test passed");
    end else begin
      $display("button_screen_backlight_controller_unit test failed");
    end
    $finish;
  end

endmodule
